// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro checks on the rising clock
// edge; SWSFP_ASSERT is quiet while the active-low synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SWSFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swsfp assertion failed");

`define SWSFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("swsfp assertion failed");

`endif

// File: hw/rtl/swsfp_pkg.sv
package swsfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int PARTIAL_W  = 24;
  localparam int UNIT_IDX_W = 2;
  localparam int ELEM_IDX_W = 4;

  localparam logic [BYTE_W-1:0] SYNC_B3 = 8'hDE;
  localparam logic [BYTE_W-1:0] SYNC_B2 = 8'hAD;
  localparam logic [BYTE_W-1:0] SYNC_B1 = 8'hBE;
  localparam logic [BYTE_W-1:0] SYNC_B0 = 8'hEF;
  localparam logic [WORD_W-1:0] SYNC_RESET = {SYNC_B3, SYNC_B2, SYNC_B1, SYNC_B0};

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_COUNT = 2'd1,
    PH_DATA  = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [UNIT_IDX_W-1:0] unit_index;
    logic [ELEM_IDX_W-1:0] element_index;
    logic [WORD_W-1:0]     value_word;
    logic                  unit_done;
  } res_t;

  typedef struct packed {
    phase_t phase;
    logic   res_valid;
  } core_status_t;

endpackage

// File: hw/rtl/swsfp_byte_if.sv
interface swsfp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [swsfp_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/swsfp_res_if.sv
interface swsfp_res_if;
  logic                              valid;
  logic                              ready;
  logic [swsfp_pkg::UNIT_IDX_W-1:0]  unit_index;
  logic [swsfp_pkg::ELEM_IDX_W-1:0]  element_index;
  logic [swsfp_pkg::WORD_W-1:0]      value_word;
  logic                              unit_done;

  modport source (output valid, output unit_index, output element_index,
                  output value_word, output unit_done, input ready);
  modport sink   (input valid, input unit_index, input element_index,
                  input value_word, input unit_done, output ready);
endinterface

// File: hw/rtl/swsfp_cfg_if.sv
interface swsfp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [swsfp_pkg::WORD_W-1:0]  sync_word;

  modport source (output valid, output sync_word, input ready);
  modport sink   (input valid, input sync_word, output ready);
endinterface

// File: hw/rtl/swsfp_core.sv
module swsfp_core #(
  parameter int MAX_UNITS       = 4,
  parameter int STATES_PER_UNIT = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [swsfp_pkg::BYTE_W-1:0] rx_byte,
  input  logic [swsfp_pkg::WORD_W-1:0] sync_word,
  output swsfp_pkg::core_status_t      status,
  output swsfp_pkg::res_t              res
);

  localparam int UCW    = $clog2(MAX_UNITS + 1);
  localparam int EW     = (STATES_PER_UNIT > 1) ? $clog2(STATES_PER_UNIT) : 1;
  localparam int SKIP_W = $clog2(255 * STATES_PER_UNIT * 4 + 1);

  swsfp_pkg::phase_t                 phase_r, phase_nxt;
  logic [1:0]                        match_r, match_nxt;
  logic [UCW-1:0]                    unit_count_r, unit_count_nxt;
  logic [UCW-1:0]                    unit_cnt_r, unit_cnt_nxt;
  logic [EW-1:0]                     elem_cnt_r, elem_cnt_nxt;
  logic [1:0]                        byte_cnt_r, byte_cnt_nxt;
  logic [swsfp_pkg::PARTIAL_W-1:0]   partial_r, partial_nxt;
  logic [SKIP_W-1:0]                 skip_r, skip_nxt;

  logic [swsfp_pkg::BYTE_W-1:0]      expect_byte;
  logic [SKIP_W-1:0]                 skip_dec;
  logic [UCW-1:0]                    unit_inc;
  logic                              elem_last;
  logic [UCW+1:0]                    unit_ext;
  logic [EW+3:0]                     elem_ext;

  // Sync bytes are expected most significant first.
  always_comb begin
    case (match_r)
      2'd0:    expect_byte = sync_word[31:24];
      2'd1:    expect_byte = sync_word[23:16];
      2'd2:    expect_byte = sync_word[15:8];
      default: expect_byte = sync_word[7:0];
    endcase
  end

  assign skip_dec  = (skip_r != '0) ? skip_r - 1'b1 : skip_r;
  assign unit_inc  = unit_cnt_r + 1'b1;
  assign elem_last = (elem_cnt_r == EW'(STATES_PER_UNIT - 1));

  always_comb begin
    phase_nxt      = phase_r;
    match_nxt      = match_r;
    unit_count_nxt = unit_count_r;
    unit_cnt_nxt   = unit_cnt_r;
    elem_cnt_nxt   = elem_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    partial_nxt    = partial_r;
    skip_nxt       = skip_r;
    if (step) begin
      case (phase_r)
        swsfp_pkg::PH_HUNT: begin
          if (rx_byte == expect_byte) begin
            if (match_r == 2'd3) begin
              match_nxt = 2'd0;
              phase_nxt = swsfp_pkg::PH_COUNT;
            end else begin
              match_nxt = match_r + 1'b1;
            end
          end else begin
            match_nxt = (rx_byte == sync_word[31:24]) ? 2'd1 : 2'd0;
          end
        end
        swsfp_pkg::PH_COUNT: begin
          if (rx_byte == '0) begin
            phase_nxt = swsfp_pkg::PH_HUNT;
            match_nxt = 2'd0;
          end else if (rx_byte > swsfp_pkg::BYTE_W'(MAX_UNITS)) begin
            skip_nxt  = SKIP_W'(rx_byte) * SKIP_W'(STATES_PER_UNIT * 4);
            phase_nxt = swsfp_pkg::PH_SKIP;
          end else begin
            // The count fits the narrow register here since it is at most MAX_UNITS.
            unit_count_nxt = rx_byte[UCW-1:0];
            unit_cnt_nxt   = '0;
            elem_cnt_nxt   = '0;
            byte_cnt_nxt   = 2'd0;
            partial_nxt    = '0;
            phase_nxt      = swsfp_pkg::PH_DATA;
          end
        end
        swsfp_pkg::PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = swsfp_pkg::PH_HUNT;
            match_nxt = 2'd0;
          end
        end
        default: begin
          if (byte_cnt_r != 2'd3) begin
            partial_nxt[{byte_cnt_r, 3'b000} +: 8] = rx_byte;
            byte_cnt_nxt = byte_cnt_r + 1'b1;
          end else begin
            byte_cnt_nxt = 2'd0;
            partial_nxt  = '0;
            if (elem_last) begin
              elem_cnt_nxt = '0;
              if (unit_inc >= unit_count_r) begin
                unit_cnt_nxt = '0;
                phase_nxt    = swsfp_pkg::PH_HUNT;
                match_nxt    = 2'd0;
              end else begin
                unit_cnt_nxt = unit_inc;
              end
            end else begin
              elem_cnt_nxt = elem_cnt_r + 1'b1;
            end
          end
        end
      endcase
    end
  end

  assign unit_ext = {2'b00, unit_cnt_r};
  assign elem_ext = {4'b0000, elem_cnt_r};

  always_comb begin
    status.phase     = phase_r;
    status.res_valid = step && (phase_r == swsfp_pkg::PH_DATA) && (byte_cnt_r == 2'd3);
    res.unit_index    = unit_ext[swsfp_pkg::UNIT_IDX_W-1:0];
    res.element_index = elem_ext[swsfp_pkg::ELEM_IDX_W-1:0];
    res.value_word    = {rx_byte, partial_r};
    res.unit_done     = elem_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= swsfp_pkg::PH_HUNT;
      match_r      <= 2'd0;
      unit_count_r <= '0;
      unit_cnt_r   <= '0;
      elem_cnt_r   <= '0;
      byte_cnt_r   <= 2'd0;
      partial_r    <= '0;
      skip_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      match_r      <= match_nxt;
      unit_count_r <= unit_count_nxt;
      unit_cnt_r   <= unit_cnt_nxt;
      elem_cnt_r   <= elem_cnt_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      partial_r    <= partial_nxt;
      skip_r       <= skip_nxt;
    end
  end

endmodule

// File: hw/rtl/sync_word_state_frame_parser.sv
// Frame parser for a byte stream: it hunts for the programmable four-byte sync
// word (reset value 0xDEADBEEF, first byte received is the most significant),
// reads a unit count, then emits one result per little-endian 32-bit word with
// its unit and element index, flagging the last element of each unit. Counts
// above MAX_UNITS make the parser drop count * STATES_PER_UNIT * 4 bytes, and
// a count of zero resumes the hunt at once. One byte is accepted every clock
// cycle; the whole parser state updates in the same cycle the byte arrives and
// a finished word appears in the output register in the cycle after its last
// byte. The output register lets the next byte in while a result waits, so the
// input only stalls when a result is pending and the sink is not ready. The
// sync word register accepts writes at any time (cfg ready stays high) and
// should only be written while the link is idle.
`include "assert_macros.svh"

module sync_word_state_frame_parser #(
  parameter int MAX_UNITS       = 4,
  parameter int STATES_PER_UNIT = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  swsfp_byte_if.sink   in_ch,
  swsfp_res_if.source  out_ch,
  swsfp_cfg_if.sink    cfg_ch
);

  logic [swsfp_pkg::WORD_W-1:0] sync_word_r;
  logic                         in_acc;
  swsfp_pkg::core_status_t      status;
  swsfp_pkg::res_t              res;
  logic                         out_valid_r, out_valid_nxt;
  swsfp_pkg::res_t              out_res_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= swsfp_pkg::SYNC_RESET;
    end else if (cfg_ch.valid) begin
      sync_word_r <= cfg_ch.sync_word;
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  swsfp_core #(
    .MAX_UNITS       (MAX_UNITS),
    .STATES_PER_UNIT (STATES_PER_UNIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_acc),
    .rx_byte   (in_ch.rx_byte),
    .sync_word (sync_word_r),
    .status    (status),
    .res       (res)
  );

  always_comb begin
    if (status.res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.unit_index    = out_res_r.unit_index;
  assign out_ch.element_index = out_res_r.element_index;
  assign out_ch.value_word    = out_res_r.value_word;
  assign out_ch.unit_done     = out_res_r.unit_done;

  // A word completes only on an accepted byte while gathering data.
  `SWSFP_ASSERT_ALWAYS(a_res_needs_byte, clk, status.res_valid |-> in_acc)
  `SWSFP_ASSERT(a_res_in_data, clk, rst_n, status.res_valid |-> status.phase == swsfp_pkg::PH_DATA)
  // The output register never fills without a completed word.
  `SWSFP_ASSERT(a_no_phantom_out, clk, rst_n, (!out_valid_r && !status.res_valid) |=> !out_valid_r)
  // A pending result that is not taken must not be overwritten.
  `SWSFP_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_ch.ready) |-> !status.res_valid)

endmodule
